### design/a51_pkg.sv
package a51_pkg;

    // register widths
    localparam int R1_W = 19;
    localparam int R2_W = 22;
    localparam int R3_W = 23;

    // feedback taps
    localparam logic [R1_W-1:0] R1_TAPS = 19'h72000;
    localparam logic [R2_W-1:0] R2_TAPS = 22'h300000;
    localparam logic [R3_W-1:0] R3_TAPS = 23'h700080;

    // clocking bit positions
    localparam int R1_CLK_BIT = 8;
    localparam int R2_CLK_BIT = 10;
    localparam int R3_CLK_BIT = 10;

    // key and frame loading
    localparam int KEY_W       = 64;
    localparam int FRAME_W     = 22;
    localparam int LOAD_STEPS  = KEY_W + FRAME_W;
    localparam int MIX_STEPS   = 100;
    localparam int CNT_W       = 7;
    localparam int POS_W       = 4;
    localparam logic [POS_W-1:0] POS_MAX = 4'd15;

    // default keystream length per frame
    localparam int KEYSTREAM_BITS_DEF = 114;

    // function codes
    localparam logic FUNC_INIT    = 1'b0;
    localparam logic FUNC_ENCRYPT = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_KEY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_NUMBER = 2'd1;

    typedef struct packed {
        logic       func;
        logic [7:0] data_in;
    } in_t;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic [7:0] keystream_byte;
        logic       overrun;
    } out_t;

    // commands from the sequencer to the register unit
    typedef struct packed {
        logic clear;
        logic step_all;
        logic step_maj;
        logic load_bit;
    } lfsr_ctrl_t;

    // status back from the register unit
    typedef struct packed {
        logic out_next;
    } lfsr_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_MIX  = 5'b00100,
        ST_GEN  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    function automatic logic [R1_W-1:0] r1_step(input logic [R1_W-1:0] r);
        return {r[R1_W-2:0], ^(r & R1_TAPS)};
    endfunction

    function automatic logic [R2_W-1:0] r2_step(input logic [R2_W-1:0] r);
        return {r[R2_W-2:0], ^(r & R2_TAPS)};
    endfunction

    function automatic logic [R3_W-1:0] r3_step(input logic [R3_W-1:0] r);
        return {r[R3_W-2:0], ^(r & R3_TAPS)};
    endfunction

endpackage

### design/a51_lfsr.sv
module a51_lfsr (
    input  logic                   clk,
    input  logic                   rst_n,
    input  a51_pkg::lfsr_ctrl_t    ctrl,
    output a51_pkg::lfsr_stat_t    stat
);

    logic [a51_pkg::R1_W-1:0] r1_reg, r1_next;
    logic [a51_pkg::R2_W-1:0] r2_reg, r2_next;
    logic [a51_pkg::R3_W-1:0] r3_reg, r3_next;
    logic ca, cb, cc, maj;

    // majority of the clocking bits
    assign ca  = r1_reg[a51_pkg::R1_CLK_BIT];
    assign cb  = r2_reg[a51_pkg::R2_CLK_BIT];
    assign cc  = r3_reg[a51_pkg::R3_CLK_BIT];
    assign maj = (ca & cb) | (ca & cc) | (cb & cc);

    // next state of the three registers: clear, step all with the load bit, majority step, or hold
    always_comb
    begin
        r1_next = r1_reg;
        r2_next = r2_reg;
        r3_next = r3_reg;
        priority if (ctrl.clear)
        begin
            r1_next = '0;
            r2_next = '0;
            r3_next = '0;
        end
        else if (ctrl.step_all)
        begin
            r1_next    = a51_pkg::r1_step(r1_reg);
            r2_next    = a51_pkg::r2_step(r2_reg);
            r3_next    = a51_pkg::r3_step(r3_reg);
            r1_next[0] = r1_next[0] ^ ctrl.load_bit;
            r2_next[0] = r2_next[0] ^ ctrl.load_bit;
            r3_next[0] = r3_next[0] ^ ctrl.load_bit;
        end
        else if (ctrl.step_maj)
        begin
            if (ca == maj)
            begin
                r1_next = a51_pkg::r1_step(r1_reg);
            end
            if (cb == maj)
            begin
                r2_next = a51_pkg::r2_step(r2_reg);
            end
            if (cc == maj)
            begin
                r3_next = a51_pkg::r3_step(r3_reg);
            end
        end
        else
        begin
            // hold
            r1_next = r1_reg;
            r2_next = r2_reg;
            r3_next = r3_reg;
        end
    end

    // keystream bit of the stepped state
    assign stat.out_next = r1_next[a51_pkg::R1_W-1] ^ r2_next[a51_pkg::R2_W-1]
                         ^ r3_next[a51_pkg::R3_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_reg <= '0;
            r2_reg <= '0;
            r3_reg <= '0;
        end
        else
        begin
            r1_reg <= r1_next;
            r2_reg <= r2_next;
            r3_reg <= r3_next;
        end
    end

endmodule

### design/a51_ctrl.sv
module a51_ctrl #(
    parameter int KEYSTREAM_BITS = a51_pkg::KEYSTREAM_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  a51_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output a51_pkg::out_t                 out_data,
    input  logic [a51_pkg::KEY_W-1:0]     key,
    input  logic [a51_pkg::FRAME_W-1:0]   frame,
    output a51_pkg::lfsr_ctrl_t           lfsr_ctrl,
    input  a51_pkg::lfsr_stat_t           lfsr_stat
);

    localparam int KS_RAW = $clog2(KEYSTREAM_BITS + 1);
    localparam int KS_W   = (KS_RAW > 7) ? KS_RAW : 7;

    a51_pkg::state_t state_reg, state_next;
    logic [a51_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [a51_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [2:0]                k_reg, k_next;
    logic [3:0]                n_reg, n_next;
    logic [7:0]                ks_reg, ks_next;
    logic [7:0]                data_reg, data_next;
    logic                      ovr_reg, ovr_next;
    logic                      out_valid_reg, out_valid_next;
    a51_pkg::out_t             out_reg, out_next;

    logic                      accept;
    logic [KS_W-1:0]           used;
    logic [KS_W-1:0]           left;
    logic                      exhausted;
    logic [3:0]                n_take;
    logic [a51_pkg::CNT_W-1:0] frame_off;
    logic                      slot_free;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == a51_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // keystream budget for this byte
    assign used      = KS_W'({pos_reg, 3'b000});
    assign left      = KS_W'(KEYSTREAM_BITS) - used;
    assign exhausted = (pos_reg == a51_pkg::POS_MAX) || (used >= KS_W'(KEYSTREAM_BITS));
    assign n_take    = (left > KS_W'(8)) ? 4'd8 : left[3:0];
    assign frame_off = cnt_reg - a51_pkg::CNT_W'(a51_pkg::KEY_W);

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        pos_next           = pos_reg;
        k_next             = k_reg;
        n_next             = n_reg;
        ks_next            = ks_reg;
        data_next          = data_reg;
        ovr_next           = ovr_reg;
        out_next           = out_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        lfsr_ctrl          = '0;
        unique case (state_reg)
            a51_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.func == a51_pkg::FUNC_INIT)
                    begin
                        lfsr_ctrl.clear = 1'b1;
                        cnt_next        = '0;
                        state_next      = a51_pkg::ST_LOAD;
                    end
                    else
                    begin
                        data_next = in_data.data_in;
                        ks_next   = '0;
                        k_next    = '0;
                        n_next    = n_take;
                        ovr_next  = exhausted;
                        state_next = exhausted ? a51_pkg::ST_OUT : a51_pkg::ST_GEN;
                    end
                end
            end
            a51_pkg::ST_LOAD:
            begin
                lfsr_ctrl.step_all = 1'b1;
                lfsr_ctrl.load_bit = (cnt_reg < a51_pkg::CNT_W'(a51_pkg::KEY_W))
                                   ? key[cnt_reg[5:0]] : frame[frame_off[4:0]];
                if (cnt_reg == a51_pkg::CNT_W'(a51_pkg::LOAD_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = a51_pkg::ST_MIX;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            a51_pkg::ST_MIX:
            begin
                lfsr_ctrl.step_maj = 1'b1;
                if (cnt_reg == a51_pkg::CNT_W'(a51_pkg::MIX_STEPS - 1))
                begin
                    pos_next   = '0;
                    state_next = a51_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            a51_pkg::ST_GEN:
            begin
                lfsr_ctrl.step_maj        = 1'b1;
                ks_next[3'd7 - k_reg]     = lfsr_stat.out_next;
                if (k_reg == 3'(n_reg - 4'd1))
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = a51_pkg::ST_OUT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            a51_pkg::ST_OUT:
            begin
                if (slot_free)
                begin
                    out_next.cipher_byte    = data_reg ^ ks_reg;
                    out_next.keystream_byte = ks_reg;
                    out_next.overrun        = ovr_reg;
                    out_valid_next          = 1'b1;
                    state_next              = a51_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = a51_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= a51_pkg::ST_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        ks_reg   <= ks_next;
        data_reg <= data_next;
        ovr_reg  <= ovr_next;
        out_reg  <= out_next;
    end

endmodule

### design/a5_1_stream_cipher.sv
// channel   direction  payload                               handshake
// in        input      in_data  {func, data_in}              in_valid / in_ready
// out       output     out_data {cipher_byte, keystream_byte, overrun}
//                                                            out_valid / out_ready
// cfg       input      cfg_index, cfg_data                   cfg_valid / cfg_ready
//
// one lfsr step per cycle, done by a single shared register unit
// initialize: clear on accept, then a load step for every key bit and frame bit, then the mixing steps
// encrypt: on accept, one step per keystream bit (8, fewer on the last byte), then the
// result moves into the output register once that is free; overrun bytes skip the steps
// the next request is taken while a result waits in the output register
// reset clears the registers, byte count and control; cfg writes are always taken
module a5_1_stream_cipher #(
    parameter int KEYSTREAM_BITS = a51_pkg::KEYSTREAM_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  a51_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output a51_pkg::out_t                     out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [a51_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [a51_pkg::KEY_W-1:0]         cfg_data
);

    logic [a51_pkg::KEY_W-1:0]   key_reg;
    logic [a51_pkg::FRAME_W-1:0] frame_reg;
    a51_pkg::lfsr_ctrl_t         lfsr_ctrl;
    a51_pkg::lfsr_stat_t         lfsr_stat;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            frame_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                a51_pkg::CFG_SESSION_KEY:
                begin
                    key_reg <= cfg_data;
                end
                a51_pkg::CFG_FRAME_NUMBER:
                begin
                    frame_reg <= cfg_data[a51_pkg::FRAME_W-1:0];
                end
                default:
                begin
                    key_reg <= key_reg;
                end
            endcase
        end
    end

    // sequencer and result register
    a51_ctrl #(
        .KEYSTREAM_BITS (KEYSTREAM_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .key       (key_reg),
        .frame     (frame_reg),
        .lfsr_ctrl (lfsr_ctrl),
        .lfsr_stat (lfsr_stat)
    );

    // shared shift register unit
    a51_lfsr u_lfsr (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lfsr_ctrl),
        .stat  (lfsr_stat)
    );

    // busy after every accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("accepted a request back to back");

    // an overrun result carries no keystream
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overrun |-> out_data.keystream_byte == 8'd0)
    else $error("overrun result with keystream bits");

    // a new result appears only as the sequencer returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
    else $error("result posted while sequencer busy");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import a51_pkg::*;

    localparam int KS_BITS     = KEYSTREAM_BITS_DEF;
    localparam int SETTLE_CYC  = 200;
    localparam int PHASE_ITEMS = 105;
    localparam int NUM_PHASES  = 9;

    // indexes past the register list, written only to check they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        logic [KEY_W-1:0]     data;
    } reg_write_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_t                  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_t                 out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KEY_W-1:0]     cfg_data  = '0;

    a5_1_stream_cipher i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial forever #5 clk = ~clk;

    // shadow copy of the cipher state and its settings
    logic [R1_W-1:0]    lfsr_a;
    logic [R2_W-1:0]    lfsr_b;
    logic [R3_W-1:0]    lfsr_c;
    logic [POS_W-1:0]   bytes_done;
    logic [KEY_W-1:0]   key_shadow;
    logic [FRAME_W-1:0] frame_shadow;

    in_t        pending_reqs[$];
    out_t       expected_bytes[$];
    reg_write_t pending_writes[$];
    int         errors = 0;

    // clock the selected registers once
    function automatic void shift_regs(input bit do_a, input bit do_b, input bit do_c);
        if (do_a)
            lfsr_a = {lfsr_a[R1_W-2:0], ^(lfsr_a & R1_TAPS)};
        if (do_b)
            lfsr_b = {lfsr_b[R2_W-2:0], ^(lfsr_b & R2_TAPS)};
        if (do_c)
            lfsr_c = {lfsr_c[R3_W-2:0], ^(lfsr_c & R3_TAPS)};
    endfunction

    // stop/go clocking: registers agreeing with the majority move
    function automatic void majority_clock();
        bit ca;
        bit cb;
        bit cc;
        bit maj;
        ca  = lfsr_a[R1_CLK_BIT];
        cb  = lfsr_b[R2_CLK_BIT];
        cc  = lfsr_c[R3_CLK_BIT];
        maj = (ca & cb) | (ca & cc) | (cb & cc);
        shift_regs(ca == maj, cb == maj, cc == maj);
    endfunction

    // key bits then frame bits, each after a full clock, then mixing
    function automatic void load_session();
        logic [KEY_W+FRAME_W-1:0] load_bits;
        load_bits = {frame_shadow, key_shadow};
        lfsr_a = '0;
        lfsr_b = '0;
        lfsr_c = '0;
        for (int i = 0; i < KEY_W + FRAME_W; i++) begin
            shift_regs(1'b1, 1'b1, 1'b1);
            lfsr_a[0] = lfsr_a[0] ^ load_bits[i];
            lfsr_b[0] = lfsr_b[0] ^ load_bits[i];
            lfsr_c[0] = lfsr_c[0] ^ load_bits[i];
        end
        repeat (MIX_STEPS) majority_clock();
        bytes_done = '0;
    endfunction

    // advance the shadow state for one request and queue the byte it yields
    function automatic void cipher_step(input in_t req);
        out_t        res;
        int unsigned used;
        int unsigned nbits;
        logic [7:0]  ks;
        if (req.func == FUNC_INIT) begin
            load_session();
            return;
        end
        used = bytes_done * 8;
        if (bytes_done >= POS_MAX || used >= KS_BITS) begin
            res.cipher_byte    = req.data_in;
            res.keystream_byte = 8'h00;
            res.overrun        = 1'b1;
        end
        else begin
            nbits = KS_BITS - used;
            if (nbits > 8)
                nbits = 8;
            ks = 8'h00;
            for (int k = 0; k < nbits; k++) begin
                majority_clock();
                ks[7-k] = lfsr_a[R1_W-1] ^ lfsr_b[R2_W-1] ^ lfsr_c[R3_W-1];
            end
            bytes_done         = bytes_done + 1'b1;
            res.cipher_byte    = req.data_in ^ ks;
            res.keystream_byte = ks;
            res.overrun        = 1'b0;
        end
        expected_bytes.push_back(res);
    endfunction

    // request driver: bursts of random length with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid     <= 1'b0;
            in_data      <= '0;
            burst_left   = 1;
            gap_left     = 0;
            lfsr_a       = '0;
            lfsr_b       = '0;
            lfsr_c       = '0;
            bytes_done   = '0;
        end
        else begin
            if (in_valid && in_ready)
                cipher_step(in_data);
            if (!in_valid || in_ready) begin
                if (gap_left > 0 || pending_reqs.size() == 0) begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else begin
                    in_valid <= 1'b1;
                    in_data  <= pending_reqs.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // register write driver, shadow settings follow accepted writes
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_valid    <= 1'b0;
            cfg_index    <= '0;
            cfg_data     <= '0;
            key_shadow   = '0;
            frame_shadow = '0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SESSION_KEY)
                    key_shadow = cfg_data;
                else if (cfg_index == CFG_FRAME_NUMBER)
                    frame_shadow = cfg_data[FRAME_W-1:0];
            end
            if (!cfg_valid || cfg_ready) begin
                if (pending_writes.size() != 0) begin
                    cfg_valid <= 1'b1;
                    cfg_index <= pending_writes[0].idx;
                    cfg_data  <= pending_writes[0].data;
                    void'(pending_writes.pop_front());
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall pattern
    int   stall_mode = 0;
    int   stall_cnt  = 0;
    out_t want;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_mode = 0;
            stall_cnt  = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got cipher %h ks %h ovr %b",
                             $time, out_data.cipher_byte, out_data.keystream_byte,
                             out_data.overrun);
                    errors++;
                end
                else begin
                    want = expected_bytes.pop_front();
                    if (out_data.cipher_byte !== want.cipher_byte ||
                        out_data.keystream_byte !== want.keystream_byte ||
                        out_data.overrun !== want.overrun) begin
                        $display("%0t: mismatch, expected cipher %h ks %h ovr %b, got cipher %h ks %h ovr %b",
                                 $time, want.cipher_byte, want.keystream_byte, want.overrun,
                                 out_data.cipher_byte, out_data.keystream_byte,
                                 out_data.overrun);
                        errors++;
                    end
                end
            end
            // modes: always ready, alternating ready and stalled, mostly ready, long stalls
            stall_cnt++;
            if (stall_cnt >= 40) begin
                stall_cnt  = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= stall_cnt[0];
                2:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ((stall_cnt % 8) == 7);
            endcase
        end
    end

    task automatic push_init();
        in_t req;
        req.func    = FUNC_INIT;
        req.data_in = 8'($urandom_range(0, 255));
        pending_reqs.push_back(req);
    endtask

    task automatic push_encrypt(input logic [7:0] data);
        in_t req;
        req.func    = FUNC_ENCRYPT;
        req.data_in = data;
        pending_reqs.push_back(req);
    endtask

    task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        pending_writes.push_back(w);
    endtask

    // wait until every request and write is through and nothing is owed
    task automatic wait_idle(input int tail);
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_bytes.size() != 0 ||
               pending_writes.size() != 0 || cfg_valid);
        repeat (tail) @(posedge clk);
    endtask

    initial begin
        int count;
        int roll;
        int nbytes;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset state: zero registers give a zero keystream, then init with zero key
        push_encrypt(8'h00);
        push_encrypt(8'hFF);
        push_init();
        push_encrypt(8'h5A);
        push_encrypt(8'hA5);
        wait_idle(SETTLE_CYC);

        // all-ones key and frame, a write to an unused index, then run past the end
        push_write(CFG_SESSION_KEY, '1);
        push_write(CFG_FRAME_NUMBER, '1);
        push_write(CFG_UNUSED_HI, '0);
        wait_idle(0);
        push_init();
        for (int i = 0; i < 16; i++)
            push_encrypt((i % 2 == 0) ? 8'h00 : 8'hFF);
        // re-init after overrun and in the middle of a stream
        push_init();
        push_encrypt(8'h3C);
        push_init();
        push_encrypt(8'hC3);
        wait_idle(SETTLE_CYC);

        // random phases, most with new settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 3)
                push_write(CFG_SESSION_KEY, 64'h1 << $urandom_range(0, 63));
            else if (ph == 6)
                push_write(CFG_SESSION_KEY, '0);
            else if ($urandom_range(0, 4) != 0)
                push_write(CFG_SESSION_KEY, {$urandom, $urandom});
            if (ph == 6)
                push_write(CFG_FRAME_NUMBER, '0);
            else if ($urandom_range(0, 4) != 0)
                push_write(CFG_FRAME_NUMBER, {$urandom, $urandom});
            if ($urandom_range(0, 2) == 0)
                push_write(($urandom_range(0, 1) != 0) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                           {$urandom, $urandom});
            wait_idle(0);

            count = 0;
            while (count < PHASE_ITEMS) begin
                roll = $urandom_range(0, 9);
                if (roll < 8) begin
                    // init then a stream, often long enough to hit the end
                    push_init();
                    nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                         : $urandom_range(12, 18);
                    for (int i = 0; i < nbytes; i++)
                        push_encrypt(8'($urandom_range(0, 255)));
                    count += nbytes + 1;
                end
                else if (roll == 8) begin
                    // stray bytes continuing whatever stream is running
                    nbytes = $urandom_range(1, 5);
                    for (int i = 0; i < nbytes; i++)
                        push_encrypt(8'($urandom_range(0, 255)));
                    count += nbytes;
                end
                else begin
                    push_init();
                    count++;
                end
            end
            wait_idle(SETTLE_CYC);
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
design/a51_pkg.sv
design/a51_lfsr.sv
design/a51_ctrl.sv
design/a5_1_stream_cipher.sv
tb/sv/testbench.sv
